@@ sv/vig52_pkg.sv @@
package vig52_pkg;

    // Alphabet and key geometry
    localparam int ALPHA_SIZE   = 52;
    localparam int SYM_W        = 6;
    localparam int KEY_MAX      = 16;
    localparam int KEY_PER_WORD = 8;
    localparam int KEY_WORD_W   = KEY_PER_WORD * SYM_W;
    localparam int LEN_W        = $clog2(KEY_MAX + 1);
    localparam int POS_W        = $clog2(KEY_MAX);
    localparam int SUM_W        = SYM_W + 1;

    // Character fields
    localparam int CHAR_W = 16;

    // ASCII letter bounds
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 16'h007A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 16'h005A;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = KEY_WORD_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECRYPT_MODE  = 2'd0,
        CFG_KEY_LENGTH    = 2'd1,
        CFG_KEY_WORD_LOW  = 2'd2,
        CFG_KEY_WORD_HIGH = 2'd3
    } cfg_index_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic                  decrypt_mode;
        logic [LEN_W-1:0]      key_length;
        logic [KEY_WORD_W-1:0] key_word_low;
        logic [KEY_WORD_W-1:0] key_word_high;
    } vig52_cfg_t;

    // One classified character waiting in the queue
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              start_of_message;
        logic              is_letter;
        logic [SYM_W-1:0]  sym_index;
    } vig52_item_t;

    // Queue status toward the front and back ends
    typedef struct packed {
        logic full;
        logic not_empty;
    } vig52_qstat_t;

endpackage

@@ sv/vig52_front.sv @@
module vig52_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tuser,
    input  vig52_pkg::vig52_qstat_t qstat,
    output logic                  push,
    output vig52_pkg::vig52_item_t push_item
);

    logic [vig52_pkg::CHAR_W-1:0] c;
    logic [vig52_pkg::CHAR_W-1:0] lower_off;
    logic [vig52_pkg::CHAR_W-1:0] upper_off;
    logic                         is_lower;
    logic                         is_upper;

    // Accept whenever the queue has room
    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;
    assign c        = s_tdata;

    // Classify the character and derive its symbol index
    always_comb begin
        is_lower  = (c >= vig52_pkg::CHAR_LOWER_A) && (c <= vig52_pkg::CHAR_LOWER_Z);
        is_upper  = (c >= vig52_pkg::CHAR_UPPER_A) && (c <= vig52_pkg::CHAR_UPPER_Z);
        lower_off = c - vig52_pkg::CHAR_LOWER_A;
        upper_off = c - vig52_pkg::CHAR_UPPER_A;

        push_item.char_code        = c;
        push_item.start_of_message = s_tuser;
        push_item.is_letter        = is_lower || is_upper;
        if (is_upper) begin
            push_item.sym_index = {upper_off[vig52_pkg::SYM_W-2:0], 1'b1};
        end else if (is_lower) begin
            push_item.sym_index = {lower_off[vig52_pkg::SYM_W-2:0], 1'b0};
        end else begin
            push_item.sym_index = '0;
        end
    end

endmodule

@@ sv/vig52_queue.sv @@
module vig52_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  vig52_pkg::vig52_item_t push_item,
    input  logic                   pop,
    output vig52_pkg::vig52_item_t head_item,
    output vig52_pkg::vig52_qstat_t qstat
);

    vig52_pkg::vig52_item_t mem [vig52_pkg::QUEUE_DEPTH];

    logic [vig52_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vig52_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [vig52_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vig52_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [vig52_pkg::QCNT_W-1:0] count_reg;
    logic [vig52_pkg::QCNT_W-1:0] count_next;

    assign qstat.full      = (count_reg == vig52_pkg::QCNT_W'(vig52_pkg::QUEUE_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign head_item       = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == vig52_pkg::QPTR_W'(vig52_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == vig52_pkg::QPTR_W'(vig52_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/vig52_back.sv @@
module vig52_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vig52_pkg::vig52_cfg_t  cfg,
    input  vig52_pkg::vig52_qstat_t qstat,
    input  vig52_pkg::vig52_item_t head_item,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tuser
);

    logic [vig52_pkg::SYM_W-1:0]  key_sym [vig52_pkg::KEY_MAX];
    logic [vig52_pkg::LEN_W-1:0]  len;
    logic [vig52_pkg::POS_W-1:0]  pos_start;
    logic [vig52_pkg::POS_W-1:0]  pos;
    logic [vig52_pkg::LEN_W-1:0]  pos_plus;
    logic [vig52_pkg::SYM_W-1:0]  key_raw;
    logic [vig52_pkg::SYM_W-1:0]  key_val;
    logic [vig52_pkg::SUM_W-1:0]  sum;
    logic [vig52_pkg::SUM_W-1:0]  sym_out;
    logic [vig52_pkg::CHAR_W-1:0] ciphered;
    logic                         no_key;

    logic [vig52_pkg::POS_W-1:0]  key_pos_reg;
    logic [vig52_pkg::POS_W-1:0]  key_pos_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [vig52_pkg::CHAR_W-1:0] m_data_reg;
    logic [vig52_pkg::CHAR_W-1:0] m_data_next;
    logic                         m_err_reg;
    logic                         m_err_next;

    // Take the head item whenever the output register is free or drains
    assign pop = qstat.not_empty && (!m_valid_reg || m_tready);

    // Split both key words into symbols
    always_comb begin
        for (int i = 0; i < vig52_pkg::KEY_MAX; i++) begin
            if (i < vig52_pkg::KEY_PER_WORD) begin
                key_sym[i] = cfg.key_word_low[i*vig52_pkg::SYM_W +: vig52_pkg::SYM_W];
            end else begin
                key_sym[i] = cfg.key_word_high[(i-vig52_pkg::KEY_PER_WORD)*vig52_pkg::SYM_W
                                                +: vig52_pkg::SYM_W];
            end
        end
    end

    // Key position, key symbol and the shift modulo the alphabet size
    always_comb begin
        len = (cfg.key_length > vig52_pkg::LEN_W'(vig52_pkg::KEY_MAX))
              ? vig52_pkg::LEN_W'(vig52_pkg::KEY_MAX) : cfg.key_length;
        no_key    = (len == '0);
        pos_start = head_item.start_of_message ? '0 : key_pos_reg;
        // A position left beyond a shortened key restarts at the first symbol
        pos       = ({1'b0, pos_start} < len) ? pos_start : '0;
        pos_plus  = {1'b0, pos} + 1'b1;

        key_raw = key_sym[pos];
        key_val = (key_raw >= vig52_pkg::SYM_W'(vig52_pkg::ALPHA_SIZE))
                  ? key_raw - vig52_pkg::SYM_W'(vig52_pkg::ALPHA_SIZE) : key_raw;

        if (cfg.decrypt_mode) begin
            sum = {1'b0, head_item.sym_index} + vig52_pkg::SUM_W'(vig52_pkg::ALPHA_SIZE)
                  - {1'b0, key_val};
        end else begin
            sum = {1'b0, head_item.sym_index} + {1'b0, key_val};
        end
        sym_out = (sum >= vig52_pkg::SUM_W'(vig52_pkg::ALPHA_SIZE))
                  ? sum - vig52_pkg::SUM_W'(vig52_pkg::ALPHA_SIZE) : sum;

        // Odd symbols are upper case
        if (sym_out[0]) begin
            ciphered = vig52_pkg::CHAR_UPPER_A
                       + vig52_pkg::CHAR_W'(sym_out[vig52_pkg::SUM_W-1:1]);
        end else begin
            ciphered = vig52_pkg::CHAR_LOWER_A
                       + vig52_pkg::CHAR_W'(sym_out[vig52_pkg::SUM_W-1:1]);
        end
    end

    // Next state of the key position and the output register
    always_comb begin
        key_pos_next = key_pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            m_err_next   = no_key;
            if (no_key) begin
                m_data_next  = head_item.char_code;
                key_pos_next = pos_start;
            end else if (head_item.is_letter) begin
                m_data_next  = ciphered;
                key_pos_next = (pos_plus >= len) ? '0 : pos_plus[vig52_pkg::POS_W-1:0];
            end else begin
                m_data_next  = head_item.char_code;
                key_pos_next = pos_start;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            key_pos_reg <= key_pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule

@@ sv/vigenere_cipher_52_symbol_core.sv @@
// Vigenere cipher over the 52-symbol alphabet a A b B ... z Z, one UTF-16
// character per request. The block takes a character every cycle while the
// queue has room and delivers one result for each: a character passes through
// the two-entry queue behind the classifying front end and then the output
// register of the cipher back end. The sustained rate of one character per
// cycle, while the output is not stalled, is set by the back end, which
// updates the key position once per character. Letters are shifted by the
// key symbol at the current key position, forward when decrypt_mode is 0 and
// backward when it is 1; other characters pass unchanged and keep the key
// position. tuser on the input restarts the key at its first symbol. With a
// key length of zero every character passes unchanged and the result's tuser
// flags the key error. Load the registers only while no request is in flight.
module vigenere_cipher_52_symbol_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [47:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] char_code
    input  logic        s_tuser,    // [0] start_of_message

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] char_out
    output logic        m_tuser     // [0] key_error
);

    vig52_pkg::vig52_cfg_t   cfg_reg;
    vig52_pkg::vig52_cfg_t   cfg_next;
    vig52_pkg::vig52_qstat_t qstat;
    vig52_pkg::vig52_item_t  push_item;
    vig52_pkg::vig52_item_t  head_item;
    logic                    push;
    logic                    pop;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (vig52_pkg::cfg_index_t'(cfg_wr_index))
                vig52_pkg::CFG_DECRYPT_MODE: begin
                    cfg_next.decrypt_mode = cfg_wr_data[0];
                end
                vig52_pkg::CFG_KEY_LENGTH: begin
                    cfg_next.key_length = cfg_wr_data[vig52_pkg::LEN_W-1:0];
                end
                vig52_pkg::CFG_KEY_WORD_LOW: begin
                    cfg_next.key_word_low = cfg_wr_data[vig52_pkg::KEY_WORD_W-1:0];
                end
                vig52_pkg::CFG_KEY_WORD_HIGH: begin
                    cfg_next.key_word_high = cfg_wr_data[vig52_pkg::KEY_WORD_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vig52_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    vig52_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    vig52_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ sv/vig52_checker.sv @@
module vig52_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       s_fire;
    logic       m_fire;

    // Count requests accepted but not yet delivered
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_fire && !m_fire) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties both sides
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // Queue plus output register never hold more than three requests
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd3)
        else $error("too many requests in flight");

    // Back pressure only when the queue really is full
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> inflight_reg >= 3'd2)
        else $error("input stalled with room in the queue");

    // A result never appears without a request behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result without a request");

endmodule

bind vigenere_cipher_52_symbol_core vig52_checker u_vig52_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/cipher_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both streams of the cipher core, works
// out the expected result of every accepted request and compares each result
// that leaves the core with the oldest one still outstanding.
module cipher_checker
    import vig52_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,
    input  logic                   s_tuser,

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [CHAR_W-1:0]      m_tdata,
    input  logic                   m_tuser,

    output int                     mismatch_count,
    output int                     outstanding
);

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              key_error;
    } cipher_result_t;

    // Shadow copy of the registers and the key position.
    logic                  dec_mode;
    logic [LEN_W-1:0]      key_len;
    logic [KEY_WORD_W-1:0] key_lo;
    logic [KEY_WORD_W-1:0] key_hi;
    logic [POS_W-1:0]      key_pos;

    cipher_result_t expected_chars[$];
    cipher_result_t want;
    int             failures = 0;

    // Ciphers one character and moves the key position along.
    function automatic cipher_result_t cipher_char(input logic [CHAR_W-1:0] code,
                                                   input logic som);
        cipher_result_t        res;
        int                    len;
        int                    sym;
        int                    pos;
        int                    shift;
        int                    sum;
        logic                  letter;
        logic [KEY_WORD_W-1:0] word;

        res.char_out  = code;
        res.key_error = 1'b0;
        letter        = 1'b0;
        sym           = 0;
        len           = (key_len > KEY_MAX) ? KEY_MAX : key_len;
        if (som) begin
            key_pos = '0;
        end

        if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            sym    = 2 * (code - CHAR_LOWER_A);
            letter = 1'b1;
        end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            sym    = 2 * (code - CHAR_UPPER_A) + 1;
            letter = 1'b1;
        end

        if (len == 0) begin
            res.key_error = 1'b1;
        end else if (letter) begin
            // A position left over from a longer key restarts at the first symbol.
            pos   = (key_pos < len) ? key_pos : 0;
            word  = (pos < KEY_PER_WORD) ? key_lo : key_hi;
            shift = word[(pos % KEY_PER_WORD) * SYM_W +: SYM_W];
            if (shift >= ALPHA_SIZE) begin
                shift -= ALPHA_SIZE;
            end
            if (dec_mode) begin
                sum = (sym + ALPHA_SIZE - shift) % ALPHA_SIZE;
            end else begin
                sum = (sym + shift) % ALPHA_SIZE;
            end
            res.char_out = (sum % 2) ? CHAR_W'(CHAR_UPPER_A + sum / 2)
                                     : CHAR_W'(CHAR_LOWER_A + sum / 2);
            pos++;
            if (pos >= len) begin
                pos = 0;
            end
            key_pos = POS_W'(pos);
        end
        return res;
    endfunction

    // Track register writes, predict on each request, check each result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            dec_mode = 1'b0;
            key_len  = '0;
            key_lo   = '0;
            key_hi   = '0;
            key_pos  = '0;
            expected_chars.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    CFG_DECRYPT_MODE:  dec_mode = cfg_wr_data[0];
                    CFG_KEY_LENGTH:    key_len  = cfg_wr_data[LEN_W-1:0];
                    CFG_KEY_WORD_LOW:  key_lo   = cfg_wr_data;
                    CFG_KEY_WORD_HIGH: key_hi   = cfg_wr_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                expected_chars.insert(expected_chars.size(), cipher_char(s_tdata, s_tuser));
            end

            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result char %h error %b with no request outstanding",
                                 $time, m_tdata, m_tuser);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.char_out || m_tuser !== want.key_error) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: expected char %h error %b, got char %h error %b",
                                     $time, want.char_out, want.key_error, m_tdata, m_tuser);
                        end
                    end
                end
            end
        end
        outstanding    <= expected_chars.size();
        mismatch_count <= failures;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import vig52_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_CHARS  = 100;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = CFG_DECRYPT_MODE;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata      = '0;
    logic                   s_tuser      = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [CHAR_W-1:0]      m_tdata;
    logic                   m_tuser;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    vigenere_cipher_52_symbol_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    cipher_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Eight key symbols, all inside the alphabet.
    function automatic logic [KEY_WORD_W-1:0] valid_key_word();
        logic [KEY_WORD_W-1:0] word;
        for (int i = 0; i < KEY_PER_WORD; i++) begin
            word[i * SYM_W +: SYM_W] = SYM_W'($urandom_range(0, ALPHA_SIZE - 1));
        end
        return word;
    endfunction

    // Key word that may hold symbols beyond the alphabet.
    function automatic logic [KEY_WORD_W-1:0] any_key_word();
        return ($urandom_range(0, 3) == 0) ? KEY_WORD_W'({$urandom, $urandom})
                                           : valid_key_word();
    endfunction

    // Mostly letters, then ASCII, full code units and the characters beside
    // the letter ranges.
    function automatic logic [CHAR_W-1:0] random_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 1) ? CHAR_W'(CHAR_UPPER_A + $urandom_range(0, 25))
                                        : CHAR_W'(CHAR_LOWER_A + $urandom_range(0, 25));
        end else if (roll < 80) begin
            return CHAR_W'($urandom_range(0, 127));
        end else if (roll < 92) begin
            return CHAR_W'($urandom_range(0, 16'hFFFF));
        end
        case ($urandom_range(0, 3))
            0:       return CHAR_W'(CHAR_UPPER_A - 1);
            1:       return CHAR_W'(CHAR_UPPER_Z + 1);
            2:       return CHAR_W'(CHAR_LOWER_A - 1);
            default: return CHAR_W'(CHAR_LOWER_Z + 1);
        endcase
    endfunction

    // Result side: ready most of the time, with stalls of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one character after a random gap and returns once it is taken.
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic som);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= som;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds off new requests until every result is back and the core is quiet.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Loads all four registers once the core is idle.
    task automatic load_config(input logic dec, input logic [LEN_W-1:0] len,
                               input logic [KEY_WORD_W-1:0] lo,
                               input logic [KEY_WORD_W-1:0] hi);
        logic [CFG_DATA_W-1:0] reg_val [4];
        cfg_index_t            reg_idx;
        drain_results();
        reg_val[CFG_DECRYPT_MODE]  = CFG_DATA_W'(dec);
        reg_val[CFG_KEY_LENGTH]    = CFG_DATA_W'(len);
        reg_val[CFG_KEY_WORD_LOW]  = lo;
        reg_val[CFG_KEY_WORD_HIGH] = hi;
        reg_idx = reg_idx.first();
        repeat (reg_idx.num()) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= reg_idx;
            cfg_wr_data  <= reg_val[reg_idx];
            @(posedge aclk);
            reg_idx = reg_idx.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [KEY_WORD_W-1:0] lo;
        logic [KEY_WORD_W-1:0] hi;
        logic [LEN_W-1:0]      len;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No key after reset: everything passes and the error flag is set.
        send_char(CHAR_LOWER_A, 1'b0);
        send_char(CHAR_UPPER_Z, 1'b1);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0035, 1'b0);

        // Short key with the largest valid symbol and one beyond the alphabet.
        lo = valid_key_word();
        lo[3 * SYM_W - 1:0] = {6'd63, 6'd51, 6'd0};
        load_config(1'b0, 5'd3, lo, {KEY_WORD_W{1'b1}});
        send_char(CHAR_LOWER_A, 1'b1);
        send_char(CHAR_UPPER_Z, 1'b0);
        send_char(CHAR_LOWER_Z, 1'b0);
        send_char(CHAR_W'(CHAR_UPPER_A - 1), 1'b0);
        send_char(CHAR_UPPER_A, 1'b0);
        send_char(CHAR_W'(CHAR_UPPER_Z + 1), 1'b0);
        send_char(CHAR_W'(CHAR_LOWER_A - 1), 1'b0);
        send_char(CHAR_W'(CHAR_LOWER_Z + 1), 1'b0);
        send_char(16'h8041, 1'b0);
        send_char(CHAR_W'(CHAR_LOWER_A + 12), 1'b1);

        // Length above the maximum in decrypt mode, then a shorter key that
        // leaves the position beyond its end.
        hi = valid_key_word();
        load_config(1'b1, 5'd31, {KEY_WORD_W{1'b1}}, hi);
        send_char(CHAR_LOWER_A, 1'b1);
        send_char(CHAR_UPPER_Z, 1'b0);
        send_char(CHAR_W'(CHAR_LOWER_A + 1), 1'b0);
        send_char(CHAR_W'(CHAR_LOWER_Z - 1), 1'b0);
        load_config(1'b1, 5'd2, {KEY_WORD_W{1'b1}}, hi);
        send_char(CHAR_W'(CHAR_LOWER_A + 2), 1'b0);
        send_char(CHAR_W'(CHAR_UPPER_A + 1), 1'b0);

        // Random phases, each with its own key; some run without any gaps.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) begin
                len = LEN_W'(KEY_MAX);
            end else if (phase == 1) begin
                len = LEN_W'(1);
            end else if (phase == 2) begin
                len = '0;
            end else if ($urandom_range(0, 9) == 0) begin
                len = LEN_W'($urandom_range(KEY_MAX + 1, 31));
            end else begin
                len = LEN_W'($urandom_range(1, KEY_MAX));
            end
            load_config((phase % 2) == 1, len, any_key_word(), any_key_word());
            quiet = (phase % 4 == 3);
            for (int n = 0; n < PHASE_CHARS; n++) begin
                send_char(random_char(), n == 0 || $urandom_range(0, 99) < 6);
            end
            quiet = 1'b0;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
